@@ rtl/core/nntt_pkg.sv @@
`default_nettype none
package nntt_pkg;

  localparam int MAX_TRACKS = 32;
  localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CNT_W = $clog2(MAX_TRACKS + 1);
  localparam int SC_W  = CNT_W + 1;

  localparam logic [15:0] W_OLD = 16'd22938;
  localparam logic [15:0] W_NEW = 16'd9830;
  localparam logic [15:0] AXIS_ONE = 16'd16384;
  localparam logic [3:0]  MISS_SAT = 4'd15;
  localparam logic [15:0] ID_LAST = 16'hFFFF;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT = 2'd1;

  typedef struct packed {
    logic               det_valid;
    logic               frame_end;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [23:0]        rad;
    logic [23:0]        hgt;
  } req_t;

  typedef struct packed {
    logic [15:0]        id;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [23:0]        rad;
    logic [23:0]        hgt;
    logic [15:0]        seen;
    logic [3:0]         missed;
  } entry_t;

  typedef struct packed {
    logic               start;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [15:0] bz;
  } norm_req_t;

  typedef struct packed {
    logic               done;
    logic               keep;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } norm_rsp_t;

endpackage
`default_nettype wire

@@ rtl/core/nntt_front.sv @@
`default_nettype none
module nntt_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  nntt_pkg::req_t      in_req,
  output logic                q_valid,
  output nntt_pkg::req_t      q_data,
  input  wire                 q_pop
);

  nntt_pkg::req_t fifo_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  // drop requests that neither carry a detection nor close a frame
  assign push = in_valid && in_ready && (in_req.det_valid || in_req.frame_end);
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      if (push && !q_pop) cnt_r <= cnt_r + 2'd1;
      else if (!push && q_pop) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/nntt_norm.sv @@
`default_nettype none
module nntt_norm (
  input  wire                    clk,
  input  wire                    rst_n,
  input  nntt_pkg::norm_req_t    req,
  output nntt_pkg::norm_rsp_t    rsp
);

  localparam logic [2:0] N_IDLE = 3'd0;
  localparam logic [2:0] N_SQ   = 3'd1;
  localparam logic [2:0] N_SQRT = 3'd2;
  localparam logic [2:0] N_DSET = 3'd3;
  localparam logic [2:0] N_DIV  = 3'd4;

  logic [2:0]         st_r;
  logic signed [15:0] b_r [3];
  logic signed [15:0] ax_r [3];
  logic [1:0]         k_r;
  logic [31:0]        n2_r;
  logic [47:0]        v_r, r_r, bit_r;
  logic [23:0]        s_r;
  logic [39:0]        rem_r;
  logic [3:0]         qb_r;
  logic [15:0]        q_r;
  logic               done_r, keep_r;

  logic [15:0] mag;
  logic [31:0] sq, n2_sum;
  logic [47:0] trial, r_next;
  logic        sq_ge;
  logic [39:0] shifted;
  logic        div_ge;
  logic [15:0] q_next, q_clamp;

  always_comb begin
    mag = b_r[k_r][15] ? 16'(-b_r[k_r]) : 16'(b_r[k_r]);
    sq = {16'd0, mag} * {16'd0, mag};
    n2_sum = n2_r + sq;
    trial = r_r + bit_r;
    sq_ge = (v_r >= trial);
    r_next = sq_ge ? ((r_r >> 1) + bit_r) : (r_r >> 1);
    shifted = {16'd0, s_r} << qb_r;
    div_ge = (rem_r >= shifted);
    q_next = div_ge ? (q_r | (16'd1 << qb_r)) : q_r;
    q_clamp = (q_next > nntt_pkg::AXIS_ONE) ? nntt_pkg::AXIS_ONE : q_next;
  end

  assign rsp.done = done_r;
  assign rsp.keep = keep_r;
  assign rsp.ax = ax_r[0];
  assign rsp.ay = ax_r[1];
  assign rsp.az = ax_r[2];

  always_ff @(posedge clk) begin
    case (st_r)
      N_IDLE: begin
        if (req.start) begin
          b_r[0] <= req.bx;
          b_r[1] <= req.by;
          b_r[2] <= req.bz;
          n2_r <= 32'd0;
          k_r <= 2'd0;
        end
      end
      N_SQ: begin
        n2_r <= n2_sum;
        k_r <= k_r + 2'd1;
        if (k_r == 2'd2) begin
          v_r <= {n2_sum, 16'd0};
          r_r <= 48'd0;
          bit_r <= 48'd1 << 46;
        end
      end
      N_SQRT: begin
        if (sq_ge) v_r <= v_r - trial;
        r_r <= r_next;
        bit_r <= bit_r >> 2;
        if (bit_r == 48'd1) begin
          s_r <= r_next[23:0];
          k_r <= 2'd0;
        end
      end
      N_DSET: begin
        rem_r <= ({24'd0, mag} << 22) + {17'd0, s_r[23:1]};
        qb_r <= 4'd15;
        q_r <= 16'd0;
      end
      N_DIV: begin
        if (div_ge) rem_r <= rem_r - shifted;
        q_r <= q_next;
        qb_r <= qb_r - 4'd1;
        if (qb_r == 4'd0) begin
          ax_r[k_r] <= b_r[k_r][15] ? 16'(-q_clamp) : q_clamp;
          k_r <= k_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= N_IDLE;
      done_r <= 1'b0;
      keep_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        N_IDLE: if (req.start) st_r <= N_SQ;
        N_SQ: begin
          if (k_r == 2'd2) begin
            if (n2_sum == 32'd0) begin
              // zero blend: keep the old axis
              done_r <= 1'b1;
              keep_r <= 1'b0;
              st_r <= N_IDLE;
            end else begin
              st_r <= N_SQRT;
            end
          end
        end
        N_SQRT: if (bit_r == 48'd1) st_r <= N_DSET;
        N_DSET: st_r <= N_DIV;
        N_DIV: begin
          if (qb_r == 4'd0) begin
            if (k_r == 2'd2) begin
              done_r <= 1'b1;
              keep_r <= 1'b1;
              st_r <= N_IDLE;
            end else begin
              st_r <= N_DSET;
            end
          end
        end
        default: st_r <= N_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/nntt_engine.sv @@
`default_nettype none
module nntt_engine (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    q_valid,
  input  nntt_pkg::req_t         q_data,
  output logic                   q_pop,
  input  wire [23:0]             match_distance,
  input  wire [3:0]              miss_limit,
  output nntt_pkg::norm_req_t    norm_req,
  input  nntt_pkg::norm_rsp_t    norm_rsp,
  output logic                   out_valid,
  input  wire                    out_ready,
  output nntt_pkg::entry_t       out_entry,
  output logic                   out_last
);

  localparam int IW = nntt_pkg::IDX_W;
  localparam int CW = nntt_pkg::CNT_W;
  localparam int SW = nntt_pkg::SC_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_BLEND = 3'd2;
  localparam logic [2:0] S_NORM  = 3'd3;
  localparam logic [2:0] S_AGE   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  nntt_pkg::entry_t table_r [nntt_pkg::MAX_TRACKS];
  logic [nntt_pkg::MAX_TRACKS-1:0] matched_r;

  logic [2:0]   st_r;
  nntt_pkg::req_t cur_r;
  logic [CW-1:0] track_count_r, old_count_r;
  logic [15:0]  next_id_r;

  logic [SW-1:0] scan_i_r;
  logic          p1_v_r, p2_v_r;
  logic [IW-1:0] p1_idx_r, p2_idx_r, best_idx_r;
  logic [23:0]   p1_dxa_r, p1_dya_r, p2_dya_r;
  logic [47:0]   p2_dx2_r, best_r;
  logic          found_r;

  logic [2:0]         bj_r;
  logic               bph_r;
  logic signed [49:0] acc_r;
  logic signed [31:0] bc_r [3];
  logic [23:0]        bs_r [2];
  logic signed [15:0] bb_r [3];
  logic               norm_start_r;

  logic [CW-1:0] age_i_r, age_w_r, emit_e_r;
  logic          out_valid_r, out_last_r;
  nntt_pkg::entry_t out_r;

  logic [IW-1:0] rd_idx;
  nntt_pkg::entry_t rd;
  logic [47:0]   md_sq;
  logic signed [32:0] dx, dy;
  logic [32:0]   dxa, dya;
  logic          issue_v;
  logic [48:0]   dist_sq;
  logic signed [32:0] opnd_o, opnd_n, mul_a;
  logic signed [15:0] mul_w;
  logic signed [48:0] prod;
  logic signed [49:0] bsum;
  logic [3:0]    age_m, age_mn;
  logic          age_inc, age_keep;
  logic [IW-1:0] age_idx;

  always_comb begin
    case (st_r)
      S_SCAN:  rd_idx = scan_i_r[IW-1:0];
      S_AGE:   rd_idx = age_i_r[IW-1:0];
      S_EMIT:  rd_idx = emit_e_r[IW-1:0];
      default: rd_idx = best_idx_r;
    endcase
  end
  assign rd = table_r[rd_idx];

  // scan front stage: XY offsets of the addressed track
  always_comb begin
    md_sq = {24'd0, match_distance} * {24'd0, match_distance};
    dx = {rd.cx[31], rd.cx} - {cur_r.cx[31], cur_r.cx};
    dy = {rd.cy[31], rd.cy} - {cur_r.cy[31], cur_r.cy};
    dxa = dx[32] ? 33'(-dx) : 33'(dx);
    dya = dy[32] ? 33'(-dy) : 33'(dy);
    // an offset of 2^24 or more can never beat match_distance squared
    issue_v = (scan_i_r < SW'(old_count_r)) && !matched_r[rd_idx] &&
              (dxa[32:24] == 9'd0) && (dya[32:24] == 9'd0);
    dist_sq = {1'b0, p2_dx2_r} + ({25'd0, p2_dya_r} * {25'd0, p2_dya_r});
  end

  // one multiply per cycle: old weight first, then new weight
  always_comb begin
    case (bj_r)
      3'd0: begin opnd_o = {rd.cx[31], rd.cx}; opnd_n = {cur_r.cx[31], cur_r.cx}; end
      3'd1: begin opnd_o = {rd.cy[31], rd.cy}; opnd_n = {cur_r.cy[31], cur_r.cy}; end
      3'd2: begin opnd_o = {rd.cz[31], rd.cz}; opnd_n = {cur_r.cz[31], cur_r.cz}; end
      3'd3: begin opnd_o = {9'd0, rd.rad}; opnd_n = {9'd0, cur_r.rad}; end
      3'd4: begin opnd_o = {9'd0, rd.hgt}; opnd_n = {9'd0, cur_r.hgt}; end
      3'd5: begin opnd_o = 33'(rd.ax); opnd_n = 33'(cur_r.ax); end
      3'd6: begin opnd_o = 33'(rd.ay); opnd_n = 33'(cur_r.ay); end
      default: begin opnd_o = 33'(rd.az); opnd_n = 33'(cur_r.az); end
    endcase
    mul_a = bph_r ? opnd_n : opnd_o;
    mul_w = bph_r ? $signed(nntt_pkg::W_NEW) : $signed(nntt_pkg::W_OLD);
    prod = mul_a * mul_w;
    bsum = acc_r + 50'(prod);
  end

  always_comb begin
    age_idx = age_i_r[IW-1:0];
    age_m = rd.missed;
    age_inc = (age_i_r < old_count_r) && !matched_r[age_idx] && (age_m != nntt_pkg::MISS_SAT);
    age_mn = age_inc ? age_m + 4'd1 : age_m;
    age_keep = (age_mn < miss_limit);
  end

  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign norm_req.start = norm_start_r;
  assign norm_req.bx = bb_r[0];
  assign norm_req.by = bb_r[1];
  assign norm_req.bz = bb_r[2];
  assign out_valid = out_valid_r;
  assign out_entry = out_r;
  assign out_last = out_last_r;

  // payload and table storage
  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
    p1_idx_r <= rd_idx;
    p1_dxa_r <= dxa[23:0];
    p1_dya_r <= dya[23:0];
    p2_idx_r <= p1_idx_r;
    p2_dx2_r <= {24'd0, p1_dxa_r} * {24'd0, p1_dxa_r};
    p2_dya_r <= p1_dya_r;
    case (st_r)
      S_IDLE: begin
        best_r <= md_sq;
      end
      S_SCAN: begin
        if (p2_v_r && (dist_sq < {1'b0, best_r})) begin
          best_r <= dist_sq[47:0];
          best_idx_r <= p2_idx_r;
        end
        if ((scan_i_r == SW'(old_count_r) + SW'(2)) && !found_r &&
            (track_count_r < CW'(nntt_pkg::MAX_TRACKS))) begin
          table_r[track_count_r[IW-1:0]] <= '{id: next_id_r, cx: cur_r.cx, cy: cur_r.cy,
            cz: cur_r.cz, ax: cur_r.ax, ay: cur_r.ay, az: cur_r.az, rad: cur_r.rad,
            hgt: cur_r.hgt, seen: 16'd1, missed: 4'd0};
        end
      end
      S_BLEND: begin
        if (!bph_r) begin
          acc_r <= 50'(prod) + 50'sd16384;
        end else begin
          case (bj_r)
            3'd0: bc_r[0] <= bsum[46:15];
            3'd1: bc_r[1] <= bsum[46:15];
            3'd2: bc_r[2] <= bsum[46:15];
            3'd3: bs_r[0] <= bsum[38:15];
            3'd4: bs_r[1] <= bsum[38:15];
            3'd5: bb_r[0] <= bsum[30:15];
            3'd6: bb_r[1] <= bsum[30:15];
            default: begin
              bb_r[2] <= bsum[30:15];
              table_r[best_idx_r] <= '{id: rd.id, cx: bc_r[0], cy: bc_r[1], cz: bc_r[2],
                ax: rd.ax, ay: rd.ay, az: rd.az, rad: bs_r[0], hgt: bs_r[1],
                seen: (rd.seen == 16'hFFFF) ? rd.seen : rd.seen + 16'd1, missed: 4'd0};
            end
          endcase
        end
      end
      S_NORM: begin
        if (norm_rsp.done && norm_rsp.keep) begin
          table_r[best_idx_r].ax <= norm_rsp.ax;
          table_r[best_idx_r].ay <= norm_rsp.ay;
          table_r[best_idx_r].az <= norm_rsp.az;
        end
      end
      S_AGE: begin
        if ((age_i_r != track_count_r) && age_keep) begin
          table_r[age_w_r[IW-1:0]] <= '{id: rd.id, cx: rd.cx, cy: rd.cy, cz: rd.cz,
            ax: rd.ax, ay: rd.ay, az: rd.az, rad: rd.rad, hgt: rd.hgt,
            seen: rd.seen, missed: age_mn};
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_r <= rd;
          out_last_r <= ((emit_e_r + CW'(1)) == track_count_r);
        end
      end
      default: begin
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      track_count_r <= '0;
      old_count_r <= '0;
      next_id_r <= 16'd1;
      matched_r <= '0;
      scan_i_r <= '0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      found_r <= 1'b0;
      bj_r <= 3'd0;
      bph_r <= 1'b0;
      norm_start_r <= 1'b0;
      age_i_r <= '0;
      age_w_r <= '0;
      emit_e_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      norm_start_r <= 1'b0;
      p1_v_r <= (st_r == S_SCAN) && issue_v;
      p2_v_r <= p1_v_r;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            scan_i_r <= '0;
            found_r <= 1'b0;
            age_i_r <= '0;
            age_w_r <= '0;
            st_r <= q_data.det_valid ? S_SCAN : S_AGE;
          end
        end
        S_SCAN: begin
          scan_i_r <= scan_i_r + SW'(1);
          if (p2_v_r && (dist_sq < {1'b0, best_r})) found_r <= 1'b1;
          if (scan_i_r == SW'(old_count_r) + SW'(2)) begin
            if (found_r) begin
              bj_r <= 3'd0;
              bph_r <= 1'b0;
              st_r <= S_BLEND;
            end else begin
              if (track_count_r < CW'(nntt_pkg::MAX_TRACKS)) begin
                matched_r[track_count_r[IW-1:0]] <= 1'b0;
                track_count_r <= track_count_r + CW'(1);
                next_id_r <= (next_id_r == nntt_pkg::ID_LAST) ? 16'd1 : next_id_r + 16'd1;
              end
              st_r <= cur_r.frame_end ? S_AGE : S_IDLE;
            end
          end
        end
        S_BLEND: begin
          bph_r <= ~bph_r;
          if (bph_r) begin
            bj_r <= bj_r + 3'd1;
            if (bj_r == 3'd7) begin
              matched_r[best_idx_r] <= 1'b1;
              norm_start_r <= 1'b1;
              st_r <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (norm_rsp.done) st_r <= cur_r.frame_end ? S_AGE : S_IDLE;
        end
        S_AGE: begin
          if (age_i_r == track_count_r) begin
            track_count_r <= age_w_r;
            old_count_r <= age_w_r;
            matched_r <= '0;
            emit_e_r <= '0;
            st_r <= (age_w_r == '0) ? S_IDLE : S_EMIT;
          end else begin
            age_i_r <= age_i_r + CW'(1);
            if (age_keep) age_w_r <= age_w_r + CW'(1);
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            emit_e_r <= emit_e_r + CW'(1);
            if ((emit_e_r + CW'(1)) == track_count_r) st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/nearest_neighbor_track_table_core.sv @@
// Search: a detection is scanned against every old track after it leaves the queue;
//   a match adds a blend of each field and an axis renormalization.
// Throughput: one request at a time in the back end; a two-deep request queue in front.
// Frame end: aging/compaction pass, then one result per cycle while out_ready is high.
// Reset (rst_n low, synchronous): counts clear, next id is 1, match flags clear;
//   table contents are not cleared and are never read before being written.
`default_nettype none
module nearest_neighbor_track_table_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_detection_valid,
  input  wire         in_frame_end,
  input  wire [31:0]  in_center_x,
  input  wire [31:0]  in_center_y,
  input  wire [31:0]  in_center_z,
  input  wire [15:0]  in_axis_x,
  input  wire [15:0]  in_axis_y,
  input  wire [15:0]  in_axis_z,
  input  wire [23:0]  in_cyl_radius,
  input  wire [23:0]  in_cyl_height,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [15:0] out_track_id,
  output logic signed [31:0] out_track_x,
  output logic signed [31:0] out_track_y,
  output logic signed [31:0] out_track_z,
  output logic signed [15:0] out_track_axis_x,
  output logic signed [15:0] out_track_axis_y,
  output logic signed [15:0] out_track_axis_z,
  output logic [23:0] out_track_radius,
  output logic [23:0] out_track_height,
  output logic [15:0] out_seen_total,
  output logic [3:0]  out_misses,
  output logic        out_last_track,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [nntt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [23:0]  cfg_data
);

  // configuration registers
  logic [23:0] match_distance_r;
  logic [3:0]  miss_limit_r;

  nntt_pkg::req_t    in_req, q_data;
  logic              q_valid, q_pop;
  nntt_pkg::norm_req_t norm_req;
  nntt_pkg::norm_rsp_t norm_rsp;
  nntt_pkg::entry_t  out_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_distance_r <= 24'd52429;
      miss_limit_r <= 4'd15;
    end else if (cfg_valid) begin
      case (cfg_index)
        nntt_pkg::CFG_MATCH_DIST: match_distance_r <= cfg_data;
        nntt_pkg::CFG_MISS_LIMIT: miss_limit_r <= cfg_data[3:0];
        default: begin
          // unknown index: drop the request
        end
      endcase
    end
  end

  assign in_req = '{det_valid: in_detection_valid, frame_end: in_frame_end,
    cx: in_center_x, cy: in_center_y, cz: in_center_z, ax: in_axis_x, ay: in_axis_y,
    az: in_axis_z, rad: in_cyl_radius, hgt: in_cyl_height};

  // front: hold requests and drop ones without effect
  nntt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  // back: search, update, age, compact and report the table
  nntt_engine u_engine (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .match_distance(match_distance_r), .miss_limit(miss_limit_r),
    .norm_req(norm_req), .norm_rsp(norm_rsp),
    .out_valid(out_valid), .out_ready(out_ready), .out_entry(out_entry),
    .out_last(out_last_track)
  );

  // axis renormalizer: square sum, bit-serial sqrt, restoring divide
  nntt_norm u_norm (
    .clk(clk), .rst_n(rst_n), .req(norm_req), .rsp(norm_rsp)
  );

  assign out_track_id = out_entry.id;
  assign out_track_x = out_entry.cx;
  assign out_track_y = out_entry.cy;
  assign out_track_z = out_entry.cz;
  assign out_track_axis_x = out_entry.ax;
  assign out_track_axis_y = out_entry.ay;
  assign out_track_axis_z = out_entry.az;
  assign out_track_radius = out_entry.rad;
  assign out_track_height = out_entry.hgt;
  assign out_seen_total = out_entry.seen;
  assign out_misses = out_entry.missed;

endmodule
`default_nettype wire

@@ rtl/core/nntt_checker.sv @@
`default_nettype none
module nntt_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [15:0] out_track_id,
  input wire [3:0]  out_misses,
  input wire        out_last_track
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_track_id))
    else $error("stalled result dropped or changed");

  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_track_id != 16'd0)
    else $error("result with id zero");

  a_miss_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_misses != 4'd15)
    else $error("reported track at miss saturation");

  a_last_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_last_track))
    else $error("last flag changed while stalled");

endmodule

bind nearest_neighbor_track_table_core nntt_checker u_nntt_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_track_id(out_track_id), .out_misses(out_misses), .out_last_track(out_last_track)
);
`default_nettype wire

@@ bench/tb_nearest_neighbor_track_table_core.sv @@
`default_nettype none
module tb_nearest_neighbor_track_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;   // cycles with no handshake at all
  localparam int SETTLE      = 400;    // back-end latency headroom before reconfig
  localparam int HOLD_CYCLES = 400;    // long receiver hold-off

  // one reported track, in the order the block emits them
  typedef struct packed {
    nntt_pkg::entry_t e;
    logic             last;
  } report_t;

  typedef struct {
    nntt_pkg::req_t   rq;
    bit               typed;
    nntt_pkg::entry_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_detection_valid = 1'b0;
  logic        in_frame_end = 1'b0;
  logic [31:0] in_center_x = '0, in_center_y = '0, in_center_z = '0;
  logic [15:0] in_axis_x = '0, in_axis_y = '0, in_axis_z = '0;
  logic [23:0] in_cyl_radius = '0, in_cyl_height = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_track_id;
  logic signed [31:0] out_track_x, out_track_y, out_track_z;
  logic signed [15:0] out_track_axis_x, out_track_axis_y, out_track_axis_z;
  logic [23:0] out_track_radius, out_track_height;
  logic [15:0] out_seen_total;
  logic [3:0]  out_misses;
  logic        out_last_track;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [nntt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  nearest_neighbor_track_table_core u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Track table mirror: what the block should hold after every accepted request.
  logic [23:0] max_dist = 24'd52429;
  logic [3:0]  miss_lim = 4'd15;
  int          n_tracks = 0;
  int          n_old = 0;
  int          next_id = 1;
  logic [15:0] tk_id [nntt_pkg::MAX_TRACKS];
  longint      tk_pos [nntt_pkg::MAX_TRACKS][3];
  longint      tk_dir [nntt_pkg::MAX_TRACKS][3];
  longint      tk_rad [nntt_pkg::MAX_TRACKS];
  longint      tk_hgt [nntt_pkg::MAX_TRACKS];
  int          tk_seen [nntt_pkg::MAX_TRACKS];
  int          tk_miss [nntt_pkg::MAX_TRACKS];
  bit          tk_hit [nntt_pkg::MAX_TRACKS];

  report_t     track_reports [$];   // reports still owed by the block
  report_t     want;
  row_t        rows [$];
  int          errors = 0;
  int          quiet_cycles = 0;
  logic        calm = 1'b0;         // no idling on either side while set
  int          hold_asks = 0;
  int          hold_taken = 0;
  int          hold_left = 0;

  function automatic longint blend_signed(longint o, longint n);
    longint v;
    v = longint'(nntt_pkg::W_OLD) * o + longint'(nntt_pkg::W_NEW) * n + 16384;
    return (v >= 0) ? (v >>> 15) : -((-v + 32767) >>> 15);
  endfunction

  function automatic longint blend_size(longint o, longint n);
    return (longint'(nntt_pkg::W_OLD) * o + longint'(nntt_pkg::W_NEW) * n + 16384) >>> 15;
  endfunction

  function automatic logic [63:0] square_mag(longint d);
    logic [63:0] m;
    m = (d < 0) ? -d : d;
    return m * m;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, step;
    r = '0;
    step = 64'h4000_0000_0000_0000;
    while (step > v) step = step >> 2;
    while (step != 0) begin
      if (v >= r + step) begin
        v = v - (r + step);
        r = (r >> 1) + step;
      end else begin
        r = r >> 1;
      end
      step = step >> 2;
    end
    return r;
  endfunction

  // Blend the axis and bring it back to unit length; a zero blend keeps the old axis.
  function automatic void steer_axis(int i, longint a[3]);
    longint b[3];
    logic [63:0] n2, s, mag, q;
    n2 = '0;
    for (int k = 0; k < 3; k++) begin
      b[k] = blend_signed(tk_dir[i][k], a[k]);
      n2 += square_mag(b[k]);
    end
    if (n2 == 0) return;
    s = int_sqrt(n2 << 16);
    for (int k = 0; k < 3; k++) begin
      mag = (b[k] < 0) ? -b[k] : b[k];
      q = ((mag << 22) + (s >> 1)) / s;
      if (q > nntt_pkg::AXIS_ONE) q = nntt_pkg::AXIS_ONE;
      tk_dir[i][k] = (b[k] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  // Apply one request to the mirror and queue the reports it causes.
  function automatic void track_update(nntt_pkg::req_t r);
    longint c[3], a[3];
    logic [63:0] best, d;
    logic [64:0] sum;
    int bi, w;
    report_t rp;
    if (r.det_valid) begin
      c = '{longint'($signed(r.cx)), longint'($signed(r.cy)), longint'($signed(r.cz))};
      a = '{longint'($signed(r.ax)), longint'($signed(r.ay)), longint'($signed(r.az))};
      best = 64'(max_dist) * 64'(max_dist);
      bi = -1;
      for (int i = 0; i < n_old; i++) begin
        if (tk_hit[i]) continue;
        sum = 65'(square_mag(tk_pos[i][0] - c[0])) + 65'(square_mag(tk_pos[i][1] - c[1]));
        d = sum[64] ? '1 : sum[63:0];
        if (d < best) begin
          best = d;
          bi = i;
        end
      end
      if (bi < 0) begin
        if (n_tracks < nntt_pkg::MAX_TRACKS) begin
          tk_id[n_tracks] = 16'(next_id);
          next_id = (next_id + 1) & 16'hFFFF;
          if (next_id == 0) next_id = 1;
          tk_pos[n_tracks] = c;
          tk_dir[n_tracks] = a;
          tk_rad[n_tracks] = r.rad;
          tk_hgt[n_tracks] = r.hgt;
          tk_seen[n_tracks] = 1;
          tk_miss[n_tracks] = 0;
          tk_hit[n_tracks] = 1'b0;
          n_tracks++;
        end
      end else begin
        tk_hit[bi] = 1'b1;
        for (int k = 0; k < 3; k++)
          tk_pos[bi][k] = longint'(int'(blend_signed(tk_pos[bi][k], c[k])));
        tk_rad[bi] = blend_size(tk_rad[bi], r.rad);
        tk_hgt[bi] = blend_size(tk_hgt[bi], r.hgt);
        steer_axis(bi, a);
        if (tk_seen[bi] < 65535) tk_seen[bi]++;
        tk_miss[bi] = 0;
      end
    end
    if (r.frame_end) begin
      for (int i = 0; i < n_old; i++)
        if (!tk_hit[i] && tk_miss[i] < nntt_pkg::MISS_SAT) tk_miss[i]++;
      w = 0;
      for (int i = 0; i < n_tracks; i++) begin
        if (tk_miss[i] >= miss_lim) continue;
        tk_id[w] = tk_id[i];
        tk_pos[w] = tk_pos[i];
        tk_dir[w] = tk_dir[i];
        tk_rad[w] = tk_rad[i];
        tk_hgt[w] = tk_hgt[i];
        tk_seen[w] = tk_seen[i];
        tk_miss[w] = tk_miss[i];
        w++;
      end
      n_tracks = w;
      n_old = w;
      for (int i = 0; i < nntt_pkg::MAX_TRACKS; i++) tk_hit[i] = 1'b0;
      for (int i = 0; i < w; i++) begin
        rp.e.id = tk_id[i];
        rp.e.cx = tk_pos[i][0][31:0];
        rp.e.cy = tk_pos[i][1][31:0];
        rp.e.cz = tk_pos[i][2][31:0];
        rp.e.ax = tk_dir[i][0][15:0];
        rp.e.ay = tk_dir[i][1][15:0];
        rp.e.az = tk_dir[i][2][15:0];
        rp.e.rad = tk_rad[i][23:0];
        rp.e.hgt = tk_hgt[i][23:0];
        rp.e.seen = tk_seen[i][15:0];
        rp.e.missed = tk_miss[i][3:0];
        rp.last = (i == w - 1);
        track_reports.insert(track_reports.size(), rp);
      end
    end
  endfunction

  function automatic nntt_pkg::req_t pack_req(bit dv, bit fe, longint x, longint y, longint z,
                                              longint ax, longint ay, longint az,
                                              longint rad, longint hgt);
    nntt_pkg::req_t r;
    r.det_valid = dv;
    r.frame_end = fe;
    r.cx = x[31:0];
    r.cy = y[31:0];
    r.cz = z[31:0];
    r.ax = ax[15:0];
    r.ay = ay[15:0];
    r.az = az[15:0];
    r.rad = rad[23:0];
    r.hgt = hgt[23:0];
    return r;
  endfunction

  function automatic void add_row(nntt_pkg::req_t rq, bit typed, nntt_pkg::entry_t exp_e);
    row_t rw;
    rw.rq = rq;
    rw.typed = typed;
    rw.want = exp_e;
    rows.insert(rows.size(), rw);
  endfunction

  function automatic longint spread(longint half);
    return longint'($urandom_range(32'(2 * half))) - half;
  endfunction

  // Mostly detections near live tracks with random content; the rest is noise.
  function automatic nntt_pkg::req_t random_req();
    nntt_pkg::req_t r;
    longint p[3], a[3];
    int i;
    longint half;
    half = max_dist / 2;
    if (n_tracks > 0 && $urandom_range(99) < 60) begin
      i = $urandom_range(n_tracks - 1);
      for (int k = 0; k < 3; k++) p[k] = tk_pos[i][k] + spread(half);
    end else if ($urandom_range(99) < 20) begin
      for (int k = 0; k < 3; k++) p[k] = longint'($urandom);
    end else begin
      for (int k = 0; k < 3; k++) p[k] = spread(50 * 65536);
    end
    case ($urandom_range(9))
      0: a = '{0, 0, 0};
      1: for (int k = 0; k < 3; k++) a[k] = $urandom_range(1) ? 16384 : -16384;
      default: for (int k = 0; k < 3; k++) a[k] = longint'($urandom_range(32768)) - 16384;
    endcase
    r = pack_req($urandom_range(99) >= 8, $urandom_range(99) < 20, p[0], p[1], p[2],
                 a[0], a[1], a[2], $urandom, $urandom);
    return r;
  endfunction

  // Offer one request and hold it until accepted; valid stays high on return.
  task automatic send_req(nntt_pkg::req_t r);
    in_valid <= 1'b1;
    in_detection_valid <= r.det_valid;
    in_frame_end <= r.frame_end;
    in_center_x <= r.cx;
    in_center_y <= r.cy;
    in_center_z <= r.cz;
    in_axis_x <= r.ax;
    in_axis_y <= r.ay;
    in_axis_z <= r.az;
    in_cyl_radius <= r.rad;
    in_cyl_height <= r.hgt;
    do @(posedge clk); while (!in_ready);
    track_update(r);
  endtask

  task automatic maybe_idle();
    if (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every owed report, then let the back end finish searching.
  task automatic drain();
    in_valid <= 1'b0;
    wait (track_reports.size() == 0);
    @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [nntt_pkg::CFG_IDX_W-1:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == nntt_pkg::CFG_MATCH_DIST) max_dist = val;
    else if (idx == nntt_pkg::CFG_MISS_LIMIT) miss_lim = val[3:0];
  endtask

  task automatic set_config(logic [23:0] gate, logic [3:0] lim);
    write_reg(nntt_pkg::CFG_MATCH_DIST, gate);
    write_reg(nntt_pkg::CFG_MISS_LIMIT, 24'(lim));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) begin
      maybe_idle();
      send_req(random_req());
    end
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when the sender asks for it.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asks) begin
      hold_taken <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 23);
    end
  end

  // Compare each report against the oldest owed one.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (track_reports.size() == 0) begin
        $display("%0t: unexpected report, id %0d", $time, out_track_id);
        errors++;
      end else begin
        want = track_reports.pop_front();
        check_field("track_id", want.e.id, out_track_id);
        check_field("track_x", want.e.cx, out_track_x);
        check_field("track_y", want.e.cy, out_track_y);
        check_field("track_z", want.e.cz, out_track_z);
        check_field("track_axis_x", want.e.ax, out_track_axis_x);
        check_field("track_axis_y", want.e.ay, out_track_axis_y);
        check_field("track_axis_z", want.e.az, out_track_axis_z);
        check_field("track_radius", want.e.rad, out_track_radius);
        check_field("track_height", want.e.hgt, out_track_height);
        check_field("seen_total", want.e.seen, out_seen_total);
        check_field("misses", want.e.missed, out_misses);
        check_field("last_track", want.last, out_last_track);
      end
    end
  end

  // Watchdog: too long without any handshake means the block hung.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    nntt_pkg::entry_t first;

    first = '{id: 16'd1, cx: 0, cy: 0, cz: 0, ax: 16'sd16384, ay: 0, az: 0,
              rad: 24'd65536, hgt: 24'd131072, seen: 16'd1, missed: 4'd0};
    // frame end with an empty table: nothing reported
    add_row(pack_req(0, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    // first track after reset reads back exactly as sent
    add_row(pack_req(1, 1, 0, 0, 0, 16384, 0, 0, 65536, 131072), 1, first);
    // match track 1, then a far detection opens track 2 in the same frame
    add_row(pack_req(1, 0, 6554, -6554, 1000, 0, 16384, 0, 70000, 120000), 0, '0);
    add_row(pack_req(1, 0, 10 * 65536, 0, 0, 0, 0, -16384, 1, 2), 0, '0);
    // extreme coordinates and sizes, detection on the frame-end item
    add_row(pack_req(1, 1, 32'h7FFF_FFFF, -64'sd2147483648, -64'sd2147483648,
                     -16384, -16384, 16384, 24'hFF_FFFF, 24'hFF_FFFF), 0, '0);
    // invalid item, all ones: ignored
    add_row(pack_req(0, 0, -1, -1, -1, -1, -1, -1, -1, -1), 0, '0);
    add_row(pack_req(1, 0, 32'h7FFF_FFFF, -64'sd2147483648, 32'h7FFF_FFFF,
                     16384, 16384, -16384, 0, 0), 0, '0);
    // invalid frame end: age everything
    add_row(pack_req(0, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    // zero axis blend keeps the old axis
    add_row(pack_req(1, 1, 20 * 65536, 20 * 65536, 0, 0, 0, 0, 1000, 1000), 0, '0);
    add_row(pack_req(1, 1, 20 * 65536, 20 * 65536, 5, 0, 0, 0, 3000, 500), 0, '0);
    // two tracks equally far from the next detection: lower index wins
    add_row(pack_req(1, 0, -32768, 30 * 65536, 0, 16384, 0, 0, 9, 9), 0, '0);
    add_row(pack_req(1, 1, 32768, 30 * 65536, 0, 0, 16384, 0, 7, 7), 0, '0);
    add_row(pack_req(1, 1, 0, 30 * 65536, 0, -16384, 0, 0, 8, 8), 0, '0);
    add_row(pack_req(1, 1, 0, 30 * 65536, 0, 0, -16384, 0, 8, 8), 0, '0);
    add_row(pack_req(0, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      maybe_idle();
      send_req(rows[i].rq);
      if (rows[i].typed)
        track_reports[track_reports.size() - 1] = '{rows[i].want, 1'b1};
    end

    // default distance; block the receiver so the input backs up, then pause mid-phase
    drain();
    set_config(24'd52429, 4'd15);
    hold_asks <= hold_asks + 1;
    run_random(50);
    drain();
    run_random(60);

    // widest gate: far coordinates saturate the squared distance
    drain();
    set_config(24'hFF_FFFF, 4'd3);
    run_random(90);

    // nothing ever matches: the table fills and further detections drop
    drain();
    set_config(24'd0, 4'd15);
    run_random(70);

    // miss limit zero with one detection per frame: every track dies at its frame end
    drain();
    set_config(24'd100, 4'd0);
    calm <= 1'b1;
    repeat (10)
      send_req(pack_req(1, 1, $urandom, $urandom, $urandom, 0, 0, 16384, $urandom, $urandom));

    // two-meter gate, one miss removes a track; start with a stretch of no idling
    drain();
    set_config(24'd131072, 4'd1);
    run_random(40);
    calm <= 1'b0;
    run_random(50);

    drain();
    set_config(24'($urandom_range(1, 24'hFF_FFFE)), 4'($urandom_range(2, 14)));
    run_random(90);
    send_req(pack_req(0, 1, 0, 0, 0, 0, 0, 0, 0, 0));

    drain();
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
